/* design/bps_pkg.sv */
`timescale 1ns / 1ps
package bps_pkg;

  localparam int unsigned NUM_PATTERNS = 5;
  localparam int unsigned MAX_STEPS    = 4;

  localparam logic [1:0] MODE_PLAY    = 2'd0;
  localparam logic [1:0] MODE_SILENCE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [2:0]  CONT_CODE = 3'd5;
  localparam logic [11:0] CONT_FREQ = 12'd800;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] pattern;
  } item_t;

  typedef struct packed {
    logic        tone_on;
    logic [11:0] tone_freq_hz;
    logic        idle;
  } result_t;

  typedef struct packed {
    logic [11:0] freq;
    logic [8:0]  tone_ms;
    logic [8:0]  gap_ms;
  } step_t;

  // Number of steps in each pattern.
  function automatic logic [1:0] step_count(input logic [2:0] sel);
    logic [1:0] cnt;
    unique case (sel)
      3'd0:    cnt = 2'd1;
      3'd1:    cnt = 2'd2;
      3'd2:    cnt = 2'd1;
      3'd3:    cnt = 2'd3;
      3'd4:    cnt = 2'd2;
      default: cnt = 2'd0;
    endcase
    return cnt;
  endfunction

  // Frequency, tone length and gap length of one step of one pattern.
  function automatic step_t step_rom(input logic [2:0] sel, input logic [1:0] idx);
    step_t s;
    unique case ({sel, idx})
      {3'd0, 2'd0}: s = '{freq: 12'd2700, tone_ms: 9'd50,  gap_ms: 9'd0};
      {3'd1, 2'd0}: s = '{freq: 12'd2700, tone_ms: 9'd50,  gap_ms: 9'd50};
      {3'd1, 2'd1}: s = '{freq: 12'd2700, tone_ms: 9'd50,  gap_ms: 9'd0};
      {3'd2, 2'd0}: s = '{freq: 12'd1800, tone_ms: 9'd300, gap_ms: 9'd0};
      {3'd3, 2'd0}: s = '{freq: 12'd1000, tone_ms: 9'd80,  gap_ms: 9'd40};
      {3'd3, 2'd1}: s = '{freq: 12'd1000, tone_ms: 9'd80,  gap_ms: 9'd40};
      {3'd3, 2'd2}: s = '{freq: 12'd1000, tone_ms: 9'd80,  gap_ms: 9'd0};
      {3'd4, 2'd0}: s = '{freq: 12'd1500, tone_ms: 9'd80,  gap_ms: 9'd30};
      {3'd4, 2'd1}: s = '{freq: 12'd2500, tone_ms: 9'd80,  gap_ms: 9'd0};
      default:      s = '0;
    endcase
    return s;
  endfunction

endpackage

/* design/bps_if.sv */
`timescale 1ns / 1ps
interface bps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] pattern;

  modport source (output valid, output mode, output pattern, input ready);
  modport sink   (input valid, input mode, input pattern, output ready);
endinterface

interface bps_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [11:0] tone_freq_hz;
  logic        idle;

  modport source (output valid, output tone_on, output tone_freq_hz, output idle, input ready);
  modport sink   (input valid, input tone_on, input tone_freq_hz, input idle, output ready);
endinterface

/* design/buzzer_pattern_sequencer_top.sv */
`timescale 1ns / 1ps
// A result passes through the input register, then the sequencer state and result register,
// which are written together, before it is presented on out_bus and can be taken.
// Throughput: one item per cycle while out_ready does not stall the output; the input register
// frees whenever the result register is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous): no pattern runs, no tone is held, both stages empty.
module buzzer_pattern_sequencer_top
  import bps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  bps_in_if.sink           in_bus,
  bps_out_if.source        out_bus
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    space;
  logic    take;
  result_t result;
  result_t out_result;

  assign in_item.mode    = in_bus.mode;
  assign in_item.pattern = in_bus.pattern;

  bps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_item    (in_item),
    .advance    (space),
    .item_valid (item_valid),
    .item       (item)
  );

  bps_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .result (result)
  );

  bps_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .space      (space),
    .take       (take),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_result (out_result)
  );

  assign out_bus.tone_on      = out_result.tone_on;
  assign out_bus.tone_freq_hz = out_result.tone_freq_hz;
  assign out_bus.idle         = out_result.idle;

endmodule

/* design/bps_in_stage.sv */
`timescale 1ns / 1ps
module bps_in_stage
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/bps_seq.sv */
`timescale 1ns / 1ps
module bps_seq
  import bps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  output result_t result
);

  logic        active_r, active_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        gap_r, gap_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic        hold_r, hold_nxt;
  logic [11:0] freq_r, freq_nxt;

  logic [8:0] rem_dec;
  logic [2:0] next_idx;
  step_t      cur_step;
  step_t      next_step;
  step_t      first_step;
  logic       past_end;

  assign rem_dec    = (rem_r != 9'd0) ? rem_r - 9'd1 : 9'd0;
  assign next_idx   = {1'b0, step_r} + 3'd1;
  assign cur_step   = step_rom(sel_r, step_r);
  assign next_step  = step_rom(sel_r, next_idx[1:0]);
  assign first_step = step_rom(item.pattern, 2'd0);
  assign past_end   = (next_idx >= {1'b0, step_count(sel_r)}) ||
                      (next_idx >= 3'(MAX_STEPS));

  always_comb begin
    active_nxt = active_r;
    sel_nxt    = sel_r;
    step_nxt   = step_r;
    gap_nxt    = gap_r;
    rem_nxt    = rem_r;
    hold_nxt   = hold_r;
    freq_nxt   = freq_r;
    if (take) begin
      unique case (item.mode)
        MODE_PLAY: begin
          if (item.pattern < 3'(NUM_PATTERNS)) begin
            hold_nxt   = 1'b0;
            sel_nxt    = item.pattern;
            active_nxt = 1'b1;
            step_nxt   = 2'd0;
            gap_nxt    = 1'b0;
            freq_nxt   = first_step.freq;
            rem_nxt    = first_step.tone_ms;
          end else if (item.pattern == CONT_CODE) begin
            active_nxt = 1'b0;
            step_nxt   = 2'd0;
            gap_nxt    = 1'b0;
            rem_nxt    = 9'd0;
            sel_nxt    = 3'd0;
            hold_nxt   = 1'b1;
            freq_nxt   = CONT_FREQ;
          end
        end
        MODE_SILENCE: begin
          active_nxt = 1'b0;
          step_nxt   = 2'd0;
          gap_nxt    = 1'b0;
          rem_nxt    = 9'd0;
          freq_nxt   = 12'd0;
          sel_nxt    = 3'd0;
          hold_nxt   = 1'b0;
        end
        MODE_TICK: begin
          if (active_r) begin
            if (rem_dec != 9'd0) begin
              rem_nxt = rem_dec;
            end else if (gap_r) begin
              if (past_end) begin
                active_nxt = 1'b0;
                step_nxt   = 2'd0;
                gap_nxt    = 1'b0;
                rem_nxt    = 9'd0;
                freq_nxt   = 12'd0;
              end else begin
                active_nxt = 1'b1;
                step_nxt   = next_idx[1:0];
                gap_nxt    = 1'b0;
                freq_nxt   = next_step.freq;
                rem_nxt    = next_step.tone_ms;
              end
            end else begin
              freq_nxt = 12'd0;
              if (cur_step.gap_ms != 9'd0) begin
                gap_nxt = 1'b1;
                rem_nxt = cur_step.gap_ms;
              end else begin
                active_nxt = 1'b0;
                step_nxt   = 2'd0;
                gap_nxt    = 1'b0;
                rem_nxt    = 9'd0;
              end
            end
          end
        end
        MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.tone_on      = (freq_nxt != 12'd0);
    result.tone_freq_hz = freq_nxt;
    result.idle         = !active_nxt && !hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sel_r    <= 3'd0;
      step_r   <= 2'd0;
      gap_r    <= 1'b0;
      rem_r    <= 9'd0;
      hold_r   <= 1'b0;
      freq_r   <= 12'd0;
    end else begin
      active_r <= active_nxt;
      sel_r    <= sel_nxt;
      step_r   <= step_nxt;
      gap_r    <= gap_nxt;
      rem_r    <= rem_nxt;
      hold_r   <= hold_nxt;
      freq_r   <= freq_nxt;
    end
  end

  a_silence_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.mode == MODE_SILENCE) |=> (!active_r && !hold_r && freq_r == 12'd0))
    else $error("silence item did not stop the buzzer");

  a_gap_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r |-> (freq_r == 12'd0 && active_r))
    else $error("gap phase with a tone or without a running pattern");

  a_active_excludes_hold: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (!hold_r && rem_r != 9'd0))
    else $error("running pattern overlaps a held tone or has no time left");

  a_idle_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (step_r == 2'd0 && rem_r == 9'd0 && !gap_r))
    else $error("idle sequencer left step state behind");

endmodule

/* design/bps_out_stage.sv */
`timescale 1ns / 1ps
module bps_out_stage
  import bps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  result_t result,
  output logic    space,
  output logic    take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign space      = !valid_r || out_ready;
  assign take       = item_valid && space;
  assign valid_nxt  = space ? item_valid : valid_r;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result;
    end
  end

endmodule
